FILE: rtl/core/point_set_diameter_hull_unit_defines.svh
// Assertion macros shared by the point-set diameter hull unit.
// Included by the top level; no other dependencies.
`ifndef POINT_SET_DIAMETER_HULL_UNIT_DEFINES_SVH
`define POINT_SET_DIAMETER_HULL_UNIT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define PSDH_ASSERT_IMPL(label, clk, rst, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_expr)) \
    else $error(msg);

// Implication checked in the cycle after the trigger.
`define PSDH_ASSERT_NEXT(label, clk, rst, cond, expect_expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_expr)) \
    else $error(msg);

`endif

FILE: rtl/core/psdh_pkg.sv
// Package for the point-set diameter hull unit: sizes, datapath ops, command and status structs.
// No dependencies.
package psdh_pkg;
  localparam int MaxPointsDefault = 256;
  localparam int CoordBitsDefault = 16;
  localparam int FieldBits = 16;
  localparam int SqOutBits = 33;
  localparam int RootOutBits = 17;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_CMP,   // read store[pos-1] for insertion compare
    OP_SHIFT,      // store[pos] <= store[pos-1], pos--
    OP_PLACE,      // store[pos] <= new point, count++
    OP_HULL_RD,    // fetch point i into candidate register
    OP_HULL_TOP,   // read stack top two entries
    OP_HULL_CROSS, // compute cross product terms
    OP_HULL_POP,   // evaluate sign, maybe pop
    OP_HULL_PUSH,  // push candidate
    OP_DIST_RD,    // read stack entries i and j
    OP_DIST_MUL,   // squared differences
    OP_DIST_ACC,   // add and keep maximum
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_CLEAR,
    OP_CAPTURE     // latch the accepted point
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cmp_before; // new point sorts before store[pos-1]
    logic pos_zero;
    logic full;
    logic pop_cond;   // turn <= 0 and depth allows pop
    logic sqrt_done;
  } dp_status_t;
endpackage

FILE: rtl/core/psdh_if.sv
// Valid/ready channel interface carrying one transaction payload.
// Depends on nothing; payload type is a parameter.
interface psdh_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/point_set_diameter_hull_unit.sv
// Point-set diameter hull unit: top level joining controller and datapath.
// Depends on psdh_pkg, psdh_if and point_set_diameter_hull_unit_defines.svh.
//
// Usage: points arrive one per transaction on the in channel (point_x, point_y,
// last_point). Each point is insertion-sorted into the point store: ready comes
// back once the stored points it sorts before are shifted up and it is placed.
// Points beyond MAX_POINTS are dropped but last_point still closes. The closing
// transaction starts the monotone-chain hull over the 2n-1 point visits of both
// chains: a visit reads the point and stack top, forms the cross product, pops
// and re-reads while the turn is not left, then pushes. A setup step, a read,
// multiply and accumulate per hull vertex pair, and the bit-serial root follow.
// One out transaction carries diameter_squared and diameter_root; a clear step
// then prepares the next set. A set of one point skips hull and search and
// yields zero. One point is in flight at a time; the store compare loop and the
// stack port set the pace. Reset (rst, synchronous) empties the set and drops
// a pending result; the memories hold no valid data until written. While the
// receiver stalls, the result register holds; new points are still taken, but
// a second finished set waits until the pending result has left.
module point_set_diameter_hull_unit #(
  parameter int MAX_POINTS = psdh_pkg::MaxPointsDefault,
  parameter int COORD_BITS = psdh_pkg::CoordBitsDefault
) (
  input  logic clk,
  input  logic rst,
  psdh_if.sink   in_ch,
  psdh_if.source out_ch
);
  import psdh_pkg::*;
  `include "point_set_diameter_hull_unit_defines.svh"

  localparam int CW = $clog2(MAX_POINTS+1);
  localparam int DW = $clog2(2*MAX_POINTS+1);

  dp_cmd_t cmd;
  dp_status_t status;
  logic upper, capture, out_valid;
  logic [CW-1:0] count;
  logic [DW-1:0] depth;
  logic [2*COORD_BITS+1:0] best;
  logic [COORD_BITS:0] root;
  logic [SqOutBits-1:0] res_sq;
  logic [RootOutBits-1:0] res_root;

  psdh_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_last(in_ch.payload.last_point),
    .out_valid, .out_ready(out_ch.ready),
    .status, .count, .depth,
    .cmd, .upper, .capture
  );

  psdh_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst, .cmd, .hull_phase_upper(upper),
    .in_x(in_ch.payload.point_x[COORD_BITS-1:0]),
    .in_y(in_ch.payload.point_y[COORD_BITS-1:0]),
    .status, .count, .depth, .best, .root
  );

  assign out_ch.valid = out_valid;
  assign out_ch.payload.diameter_squared = res_sq;
  assign out_ch.payload.diameter_root = res_root;

  // Result register, loaded once per set and held through stalls.
  always_ff @(posedge clk) begin
    if (capture) begin
      res_sq <= SqOutBits'(best);
      res_root <= RootOutBits'(root);
    end
  end

  `PSDH_ASSERT_IMPL(a_capture_free, clk, rst, capture, !out_valid,
    "result overwritten while pending")
  `PSDH_ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !out_ch.ready,
    out_valid && $stable(res_sq) && $stable(res_root), "result changed under stall")
  `PSDH_ASSERT_NEXT(a_accept_busy, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready,
    "second point taken while one is in flight")
endmodule

FILE: rtl/core/psdh_datapath.sv
// Datapath: point store, hull stack, cross-product, distance and square-root units.
// Depends on psdh_pkg.
module psdh_datapath #(
  parameter int MAX_POINTS = psdh_pkg::MaxPointsDefault,
  parameter int COORD_BITS = psdh_pkg::CoordBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  psdh_pkg::dp_cmd_t         cmd,
  input  logic                      hull_phase_upper,
  input  logic [COORD_BITS-1:0]     in_x,
  input  logic [COORD_BITS-1:0]     in_y,
  output psdh_pkg::dp_status_t      status,
  output logic [$clog2(MAX_POINTS+1)-1:0] count,
  output logic [$clog2(2*MAX_POINTS+1)-1:0] depth,
  output logic [2*COORD_BITS+1:0]   best,
  output logic [COORD_BITS:0]       root
);
  import psdh_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS+1);
  localparam int SAW = $clog2(2*MAX_POINTS);
  localparam int DW = $clog2(2*MAX_POINTS+1);
  localparam int PW = 2*COORD_BITS;
  localparam int DIFW = COORD_BITS+1;
  localparam int PRW = 2*DIFW;
  localparam int BW = 2*COORD_BITS+2;
  localparam int RW = COORD_BITS+1;
  localparam int SQW = 2*RW;

  logic [PW-1:0] store_mem [MAX_POINTS];
  logic [PW-1:0] stack_mem [2*MAX_POINTS];

  logic [CW-1:0] pos;
  logic [PW-1:0] cmp_pt;      // registered store read
  logic [PW-1:0] cand;        // point being inserted or added to the hull
  logic [CW-1:0] idx;         // hull walk index
  logic [DW-1:0] lower;       // floor depth for the upper chain
  logic [PW-1:0] top_a, top_b;// stack[depth-2], stack[depth-1]
  logic signed [PRW-1:0] prod_a, prod_b;
  logic [DW-1:0] di, dj;
  logic [PW-1:0] pi, pj;
  logic [PRW-1:0] sq_a, sq_b;
  logic [BW-1:0] rem;
  logic [SQW-1:0] sq_res, sq_bit;

  function automatic logic sorts_first(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    begin
      ax = a[PW-1:COORD_BITS]; ay = a[COORD_BITS-1:0];
      bx = b[PW-1:COORD_BITS]; by = b[COORD_BITS-1:0];
      sorts_first = (ax != bx) ? (ax < bx) : (ay < by);
    end
  endfunction

  function automatic logic signed [DIFW-1:0] dif(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
    dif = DIFW'($signed(a)) - DIFW'($signed(b));
  endfunction

  logic signed [DIFW-1:0] c_ax, c_ay, c_bx, c_by, d_x, d_y;
  logic signed [PRW:0] turn_v;
  logic [PRW:0] dsum;
  logic [BW-1:0] trial;

  assign c_ax = dif(top_b[PW-1:COORD_BITS], top_a[PW-1:COORD_BITS]);
  assign c_ay = dif(top_b[COORD_BITS-1:0], top_a[COORD_BITS-1:0]);
  assign c_bx = dif(cand[PW-1:COORD_BITS], top_a[PW-1:COORD_BITS]);
  assign c_by = dif(cand[COORD_BITS-1:0], top_a[COORD_BITS-1:0]);
  assign d_x = dif(pi[PW-1:COORD_BITS], pj[PW-1:COORD_BITS]);
  assign d_y = dif(pi[COORD_BITS-1:0], pj[COORD_BITS-1:0]);
  assign turn_v = (PRW+1)'(prod_a) - (PRW+1)'(prod_b);
  assign dsum = (PRW+1)'(sq_a) + (PRW+1)'(sq_b);
  assign trial = BW'(sq_res) + BW'(sq_bit);

  assign status.cmp_before = sorts_first(cand, cmp_pt);
  assign status.pos_zero = (pos == '0);
  assign status.full = (count == CW'(MAX_POINTS));
  assign status.pop_cond = (depth >= DW'(2)) &&
                           (!hull_phase_upper || depth > lower) && (turn_v <= 0);
  assign status.sqrt_done = (sq_bit == '0);
  assign root = RW'(sq_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      depth <= '0;
      best <= '0;
      pos <= '0;
      idx <= '0;
      lower <= '0;
    end else begin
      case (cmd.op)
        OP_NONE: ;
        OP_CAPTURE: begin
          cand <= {in_x, in_y};
        end
        OP_LOAD_CMP: begin
          cmp_pt <= store_mem[AW'(pos - CW'(1))];
        end
        OP_SHIFT: begin
          store_mem[AW'(pos)] <= cmp_pt;
          pos <= pos - CW'(1);
        end
        OP_PLACE: begin
          store_mem[AW'(pos)] <= cand;
          count <= count + CW'(1);
          pos <= count + CW'(1);
        end
        OP_HULL_RD: begin
          cand <= store_mem[AW'(idx)];
        end
        OP_HULL_TOP: begin
          top_a <= stack_mem[SAW'(depth - DW'(2))];
          top_b <= stack_mem[SAW'(depth - DW'(1))];
        end
        OP_HULL_CROSS: begin
          prod_a <= c_ax * c_by;
          prod_b <= c_ay * c_bx;
        end
        OP_HULL_POP: begin
          if (status.pop_cond) depth <= depth - DW'(1);
        end
        OP_HULL_PUSH: begin
          if (depth < DW'(2*MAX_POINTS)) begin
            stack_mem[SAW'(depth)] <= cand;
            depth <= depth + DW'(1);
          end
          if (!hull_phase_upper) begin
            if (idx == count - CW'(1)) begin
              lower <= depth + DW'(1);
              idx <= count - CW'(2);
            end else begin
              idx <= idx + CW'(1);
            end
          end else begin
            idx <= idx - CW'(1);
          end
          di <= '0;
          dj <= DW'(1);
        end
        OP_DIST_RD: begin
          pi <= stack_mem[SAW'(di)];
          pj <= stack_mem[SAW'(dj)];
        end
        OP_DIST_MUL: begin
          sq_a <= PRW'(d_x * d_x);
          sq_b <= PRW'(d_y * d_y);
        end
        OP_DIST_ACC: begin
          if (BW'(dsum) > best) best <= BW'(dsum);
          if (dj + DW'(1) >= depth - DW'(1)) begin
            di <= di + DW'(1);
            dj <= di + DW'(2);
          end else begin
            dj <= dj + DW'(1);
          end
        end
        OP_SQRT_INIT: begin
          rem <= best;
          sq_res <= '0;
          sq_bit <= SQW'(1) << (SQW - 2);
        end
        OP_SQRT_STEP: begin
          // no step once the bit has shifted out
          if (!status.sqrt_done) begin
            if (rem >= trial) begin
              rem <= rem - trial;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        OP_CLEAR: begin
          count <= '0;
          depth <= '0;
          best <= '0;
          pos <= '0;
          idx <= '0;
          lower <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/core/psdh_ctrl.sv
// Controller state machine sequencing insertion, hull build, pair search and root.
// Depends on psdh_pkg.
module psdh_ctrl #(
  parameter int MAX_POINTS = psdh_pkg::MaxPointsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  psdh_pkg::dp_status_t status,
  input  logic [$clog2(MAX_POINTS+1)-1:0] count,
  input  logic [$clog2(2*MAX_POINTS+1)-1:0] depth,
  output psdh_pkg::dp_cmd_t    cmd,
  output logic                 upper,
  output logic                 capture
);
  import psdh_pkg::*;

  localparam int CW = $clog2(MAX_POINTS+1);
  localparam int DW = $clog2(2*MAX_POINTS+1);

  typedef enum logic [4:0] {
    S_IDLE, S_CMP, S_CMP_WAIT, S_DECIDE, S_SHIFT, S_PLACE, S_CHECK_LAST,
    S_H_RD, S_H_TOP, S_H_CROSS, S_H_POP, S_H_PUSH,
    S_D_FIX, S_D_RD, S_D_MUL, S_D_ACC, S_SQ_INIT, S_SQ_STEP, S_OUT, S_CLEAR
  } state_t;

  state_t state;
  logic last;
  logic [CW-1:0] steps;   // points remaining in the current chain walk
  logic [DW-1:0] di, dj;

  assign in_ready = (state == S_IDLE);
  // result register loads once the previous result has left
  assign capture = (state == S_OUT) && !out_valid;

  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: if (in_valid) cmd.op = OP_CAPTURE;
      S_CMP: cmd.op = OP_LOAD_CMP;
      S_SHIFT: cmd.op = OP_SHIFT;
      S_PLACE: cmd.op = OP_PLACE;
      S_H_RD: cmd.op = OP_HULL_RD;
      S_H_TOP: cmd.op = OP_HULL_TOP;
      S_H_CROSS: cmd.op = OP_HULL_CROSS;
      S_H_POP: cmd.op = OP_HULL_POP;
      S_H_PUSH: cmd.op = OP_HULL_PUSH;
      S_D_RD: cmd.op = OP_DIST_RD;
      S_D_MUL: cmd.op = OP_DIST_MUL;
      S_D_ACC: cmd.op = OP_DIST_ACC;
      S_SQ_INIT: cmd.op = OP_SQRT_INIT;
      S_SQ_STEP: cmd.op = OP_SQRT_STEP;
      S_CLEAR: cmd.op = OP_CLEAR;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last <= 1'b0;
      out_valid <= 1'b0;
      upper <= 1'b0;
      steps <= '0;
      di <= '0;
      dj <= '0;
    end else begin
      if (capture) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          last <= in_last;
          state <= status.full ? S_CHECK_LAST : S_CMP;
        end
        S_CMP: state <= S_CMP_WAIT;
        S_CMP_WAIT: state <= S_DECIDE;
        S_DECIDE: state <= (!status.pos_zero && status.cmp_before) ? S_SHIFT : S_PLACE;
        S_SHIFT: state <= S_CMP;
        S_PLACE: state <= S_CHECK_LAST;
        S_CHECK_LAST: begin
          if (!last) state <= S_IDLE;
          else if (count <= CW'(1)) state <= S_SQ_INIT;
          else begin
            upper <= 1'b0;
            steps <= count;
            state <= S_H_RD;
          end
        end
        S_H_RD: state <= S_H_TOP;
        S_H_TOP: state <= S_H_CROSS;
        S_H_CROSS: state <= S_H_POP;
        S_H_POP: state <= status.pop_cond ? S_H_TOP : S_H_PUSH;
        S_H_PUSH: begin
          if (!upper && steps == CW'(1)) begin
            upper <= 1'b1;
            steps <= count - CW'(1);
            state <= S_H_RD;
          end else if (upper && steps == CW'(1)) begin
            state <= S_D_FIX;
          end else begin
            steps <= steps - CW'(1);
            state <= S_H_RD;
          end
        end
        S_D_FIX: begin
          // effective depth is depth-1 (closing point dropped)
          di <= '0;
          dj <= DW'(1);
          state <= (depth - DW'(1) > DW'(1)) ? S_D_RD : S_SQ_INIT;
        end
        S_D_RD: state <= S_D_MUL;
        S_D_MUL: state <= S_D_ACC;
        S_D_ACC: begin
          if (dj + DW'(1) >= depth - DW'(1)) begin
            if (di + DW'(2) >= depth - DW'(1)) state <= S_SQ_INIT;
            else begin
              di <= di + DW'(1);
              dj <= di + DW'(2);
              state <= S_D_RD;
            end
          end else begin
            dj <= dj + DW'(1);
            state <= S_D_RD;
          end
        end
        S_SQ_INIT: state <= S_SQ_STEP;
        S_SQ_STEP: if (status.sqrt_done) state <= S_OUT;
        S_OUT: if (!out_valid) state <= S_CLEAR;
        S_CLEAR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: verif/psdh_tb_types_pkg.sv
`timescale 1ns / 100ps
// Transaction payload types for the diameter hull unit testbench.
// Depends on psdh_pkg for the field widths.
package psdh_tb_types_pkg;
  import psdh_pkg::*;

  typedef struct packed {
    logic signed [FieldBits-1:0] point_x;
    logic signed [FieldBits-1:0] point_y;
    logic                        last_point;
  } point_in_t;

  typedef struct packed {
    logic [SqOutBits-1:0]   diameter_squared;
    logic [RootOutBits-1:0] diameter_root;
  } diam_out_t;
endpackage

FILE: verif/psdh_diameter_checker.sv
`timescale 1ns / 100ps
// Checker for the diameter hull unit: rebuilds each point set, predicts the
// hull diameter and compares the out channel. Depends on psdh_tb_types_pkg.
module psdh_diameter_checker
  import psdh_pkg::*;
  import psdh_tb_types_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  point_in_t in_pt,
  input  logic      out_valid,
  input  logic      out_ready,
  input  diam_out_t out_res,
  output int        errors,
  output int        pending,
  output int        sets_closed
);
  longint    set_x[MAX_POINTS];
  longint    set_y[MAX_POINTS];
  int        set_count;
  diam_out_t diameters_due[$];

  function automatic longint hull_turn(longint ox, longint oy, longint ax, longint ay,
                                       longint bx, longint by);
    return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
  endfunction

  function automatic diam_out_t set_diameter();
    longint    hx[2*MAX_POINTS];
    longint    hy[2*MAX_POINTS];
    int        depth;
    int        lower;
    int        k;
    longint    dx;
    longint    dy;
    longint    d;
    longint    best;
    longint    root;
    longint    trial;
    diam_out_t res;
    depth = 0;
    best  = 0;
    if (set_count > 1) begin
      // lower chain, then upper chain walked backward
      for (int i = 0; i < 2 * set_count - 1; i++) begin
        k = (i < set_count) ? i : 2 * set_count - 2 - i;
        if (i == set_count) lower = depth;
        while (depth >= 2 && (i < set_count || depth > lower) &&
               hull_turn(hx[depth-2], hy[depth-2], hx[depth-1], hy[depth-1],
                         set_x[k], set_y[k]) <= 0)
          depth--;
        hx[depth] = set_x[k];
        hy[depth] = set_y[k];
        depth++;
      end
      if (depth > 1) depth--;
      for (int i = 0; i < depth; i++)
        for (int j = i + 1; j < depth; j++) begin
          dx = hx[i] - hx[j];
          dy = hy[i] - hy[j];
          d  = dx * dx + dy * dy;
          if (d > best) best = d;
        end
    end
    root = 0;
    for (int b = RootOutBits - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= best) root = trial;
    end
    res.diameter_squared = best[SqOutBits-1:0];
    res.diameter_root    = root[RootOutBits-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    int        pos;
    diam_out_t want;
    if (rst) begin
      set_count = 0;
      diameters_due.delete();
      errors      <= 0;
      sets_closed <= 0;
      pending     <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (set_count < MAX_POINTS) begin
          // keep the set ordered by x, then y
          pos = set_count;
          while (pos > 0 && (in_pt.point_x < set_x[pos-1] ||
                 (in_pt.point_x == set_x[pos-1] && in_pt.point_y < set_y[pos-1]))) begin
            set_x[pos] = set_x[pos-1];
            set_y[pos] = set_y[pos-1];
            pos--;
          end
          set_x[pos] = in_pt.point_x;
          set_y[pos] = in_pt.point_y;
          set_count  = set_count + 1;
        end
        if (in_pt.last_point) begin
          diameters_due = {diameters_due, set_diameter()};
          set_count = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (diameters_due.size() == 0) begin
          $display("%0t: unexpected result sq=%0d root=%0d", $time,
                   out_res.diameter_squared, out_res.diameter_root);
          errors <= errors + 1;
        end else begin
          want = diameters_due.pop_front();
          sets_closed <= sets_closed + 1;
          if (want.diameter_squared !== out_res.diameter_squared) begin
            $display("%0t: diameter_squared expected %0d actual %0d", $time,
                     want.diameter_squared, out_res.diameter_squared);
            errors <= errors + 1;
          end else if (want.diameter_root !== out_res.diameter_root) begin
            $display("%0t: diameter_root expected %0d actual %0d", $time,
                     want.diameter_root, out_res.diameter_root);
            errors <= errors + 1;
          end
        end
      end
      pending <= diameters_due.size();
    end
  end
endmodule

FILE: verif/point_set_diameter_hull_unit_tb.sv
`timescale 1ns / 100ps
// Top of the diameter hull unit testbench: clock, reset, point stimulus,
// result back-pressure and verdict. Depends on psdh_tb_types_pkg and the checker.
module point_set_diameter_hull_unit_tb;
  import psdh_pkg::*;
  import psdh_tb_types_pkg::*;

  localparam int MAX_POINTS = MaxPointsDefault;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   sets_closed;
  int   points_sent;
  bit   rx_hold_req;   // asks the receiver for one long hold-off
  bit   no_idle;       // stretch with no gaps on either side

  psdh_if #(.payload_t(point_in_t)) in_ch (clk);
  psdh_if #(.payload_t(diam_out_t)) out_ch (clk);

  point_set_diameter_hull_unit #(.MAX_POINTS(MAX_POINTS)) DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  psdh_diameter_checker #(.MAX_POINTS(MAX_POINTS)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_pt      (in_ch.payload),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (out_ch.payload),
    .errors     (errors),
    .pending    (pending),
    .sets_closed(sets_closed)
  );

  always #10 clk = ~clk;

  // Hard stop against a hung run.
  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

  // Sender: one point transaction, with a random gap ahead of it. Valid stays
  // high across back-to-back transactions so it is never dropped and re-raised
  // in one step.
  task automatic send_point(input int x, input int y, input bit last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.payload.point_x    <= x[15:0];
    in_ch.payload.point_y    <= y[15:0];
    in_ch.payload.last_point <= last;
    in_ch.valid              <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
  endtask

  // Random coordinate: full range for grid 0 so every bit toggles, otherwise a
  // small grid so duplicates and collinear points are common.
  function automatic int rand_coord(input int grid);
    if (grid > 0) return $urandom_range(0, grid) - grid / 2;
    return $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic send_set(input int n, input int grid);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(grid), rand_coord(grid), i == n - 1);
  endtask

  // Receiver: random ready gaps, plus one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int n;
    int grid;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    points_sent = 0;
    rx_hold_req = 1'b0;
    no_idle     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single point, corner extremes, duplicates, collinear points.
    send_point(0, 0, 1);
    send_point(-32768, -32768, 1);
    send_point(-32768, -32768, 0);
    send_point(32767, 32767, 1);                 // largest possible diameter
    send_point(32767, -32768, 0);
    send_point(-32768, 32767, 1);
    send_point(5, 5, 0);
    send_point(5, 5, 0);
    send_point(5, 5, 1);                          // all duplicates
    send_point(-3, -3, 0);
    send_point(1, 1, 0);
    send_point(-1, -1, 0);
    send_point(7, 7, 1);                          // collinear
    send_point(10, 0, 0);
    send_point(0, 10, 0);
    send_point(-10, 0, 0);
    send_point(0, -10, 0);
    send_point(0, 0, 0);
    send_point(10, 0, 1);                         // diamond, inner point, duplicate
    send_point(-1, 0, 0);
    send_point(-1, 2, 1);                         // vertical pair

    // Sender pauses until every expected result has come back.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Receiver holds off long while the sender keeps offering one-point sets,
    // so the result register fills and input stalls.
    rx_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_point(rand_coord(0), rand_coord(0), 1);

    // Overflow: ascending x keeps insertion cheap; the closing mark arrives on
    // a dropped point.
    for (int i = 0; i < MAX_POINTS + 3; i++)
      send_point(i * 200 - 30000, rand_coord(0), i == MAX_POINTS + 2);
    // One full set in random order.
    send_set(MAX_POINTS, 0);

    // Random sets, mostly small; a stretch without idling in the middle.
    while (points_sent < 1600) begin
      no_idle = (points_sent > 900 && points_sent < 1050);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 2))
        0: grid = 0;
        1: grid = 6;
        default: grid = $urandom_range(1, 2000);
      endcase
      send_set(n, grid);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d points in %0d closed sets: extremes, duplicates, collinear,",
             points_sent, sets_closed);
    $display("store overflow, a full set, long output stall and back-pressure.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/psdh_pkg.sv
rtl/core/psdh_if.sv
rtl/core/psdh_datapath.sv
rtl/core/psdh_ctrl.sv
rtl/core/point_set_diameter_hull_unit.sv
verif/psdh_tb_types_pkg.sv
verif/psdh_diameter_checker.sv
verif/point_set_diameter_hull_unit_tb.sv
